### rtl/lppr_pkg.sv
// Shared types and codes for the length-prefixed packet receiver.
// Holds the status and phase codes and the pipeline stage record.
// No dependencies.
package lppr_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_DONE  = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_DISCARDED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_READY   = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    localparam int RX_BYTE_W  = 8;
    localparam int READ_IDX_W = 10;

    typedef struct packed {
        t_status status;
        t_phase  phase;
        logic    packet_ready;
        logic    rd_hit;
    } t_stage;

    typedef struct packed {
        t_status                status;
        logic [RX_BYTE_W-1:0]   read_value;
        t_phase                 phase;
        logic                   packet_ready;
    } t_result;

endpackage

### rtl/lppr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lppr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/length_prefixed_packet_receiver_top.sv
// Length-prefixed packet receiver, top level.
// Depends on lppr_pkg and lppr_ram.
//
// Usage:
// The request channel (i_valid / o_stall) carries either a received serial
// byte (i_action 0) or a read of the stored packet (i_action 1). The block
// gathers a HEADER_BYTES little-endian length header, stores that many
// payload bytes in a BUF_DEPTH-byte buffer and then holds the packet until a
// read with i_read_last set releases it. Bytes arriving while a packet is
// held are dropped with a discard status.
// The result channel (o_valid / i_stall) returns exactly one result per
// request: status, read value, phase after the request and packet_ready.
// Each accepted request is registered in the front stage, together with the
// registered read of the packet buffer, and then in the result register.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds, then the stage in
// front of it holds, and o_stall rises once both are full.
// Reset returns the block to the header phase with empty pipeline; the
// buffer contents are not cleared and are only read below the received
// length.
module length_prefixed_packet_receiver_top #(
    parameter int BUF_DEPTH    = 1024,
    parameter int HEADER_BYTES = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_action,
    input  logic [lppr_pkg::RX_BYTE_W-1:0]   i_rx_byte,
    input  logic [lppr_pkg::READ_IDX_W-1:0]  i_read_index,
    input  logic                             i_read_last,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_status,
    output logic [lppr_pkg::RX_BYTE_W-1:0]   o_read_value,
    output logic [1:0]                       o_phase,
    output logic                             o_packet_ready
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int PW = $clog2(BUF_DEPTH + 1);
    localparam int MW = (PW > lppr_pkg::READ_IDX_W) ? PW : lppr_pkg::READ_IDX_W;

    lppr_pkg::t_phase  r_phase, n_phase;
    logic [PW-1:0]     r_pos, n_pos;
    logic [31:0]       r_accum, n_accum;
    logic [PW-1:0]     r_expected, n_expected;
    logic [PW-1:0]     r_recv, n_recv;

    lppr_pkg::t_stage  r_s1, n_s1;
    logic              r_s1_valid;
    lppr_pkg::t_result r_out;
    logic              r_out_valid;

    logic                        accept;
    logic                        out_free;
    logic                        s1_adv;
    logic [PW-1:0]               pos_inc;
    logic [31:0]                 hdr_next;
    logic [MW-1:0]               idx_ext;
    logic                        wr_en;
    logic [lppr_pkg::RX_BYTE_W-1:0] rd_data;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    assign pos_inc  = r_pos + PW'(1);
    assign hdr_next = r_accum | (32'(i_rx_byte) << {r_pos[1:0], 3'b000});
    assign idx_ext  = MW'(i_read_index);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_accum    = r_accum;
        n_expected = r_expected;
        n_recv     = r_recv;
        wr_en      = 1'b0;
        n_s1.status       = lppr_pkg::ST_OK;
        n_s1.packet_ready = 1'b0;
        n_s1.rd_hit       = 1'b0;
        if (!i_action) begin
            case (r_phase)
                lppr_pkg::PH_READY: begin
                    n_accum = hdr_next;
                    n_pos   = pos_inc;
                    if (pos_inc >= PW'(HEADER_BYTES)) begin
                        n_pos      = '0;
                        n_accum    = '0;
                        n_expected = '0;
                        if (hdr_next > 32'(BUF_DEPTH)) begin
                            n_s1.status = lppr_pkg::ST_TOO_LARGE;
                        end else if (hdr_next == '0) begin
                            n_recv            = '0;
                            n_phase           = lppr_pkg::PH_DONE;
                            n_s1.packet_ready = 1'b1;
                        end else begin
                            n_expected = PW'(hdr_next);
                            n_phase    = lppr_pkg::PH_PAYLOAD;
                        end
                    end
                end
                lppr_pkg::PH_PAYLOAD: begin
                    wr_en = 1'b1;
                    n_pos = pos_inc;
                    if (pos_inc >= r_expected) begin
                        n_recv            = r_expected;
                        n_pos             = '0;
                        n_accum           = '0;
                        n_expected        = '0;
                        n_phase           = lppr_pkg::PH_DONE;
                        n_s1.packet_ready = 1'b1;
                    end
                end
                default: begin
                    n_s1.status = lppr_pkg::ST_DISCARDED;
                end
            endcase
        end else if (r_phase != lppr_pkg::PH_DONE) begin
            n_s1.status = lppr_pkg::ST_NOT_DONE;
        end else begin
            n_s1.rd_hit = idx_ext < MW'(r_recv);
            if (i_read_last) begin
                n_phase    = lppr_pkg::PH_READY;
                n_pos      = '0;
                n_accum    = '0;
                n_expected = '0;
                n_recv     = '0;
            end
        end
        n_s1.phase = n_phase;
    end

    lppr_ram #(
        .WIDTH (lppr_pkg::RX_BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr_en),
        .i_wr_addr (r_pos[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (accept),
        .i_rd_addr (idx_ext[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lppr_pkg::PH_READY;
            r_pos       <= '0;
            r_accum     <= '0;
            r_expected  <= '0;
            r_recv      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_accum    <= n_accum;
                r_expected <= n_expected;
                r_recv     <= n_recv;
                r_s1       <= n_s1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid         <= 1'b1;
                r_out.status        <= r_s1.status;
                r_out.read_value    <= r_s1.rd_hit ? rd_data : '0;
                r_out.phase         <= r_s1.phase;
                r_out.packet_ready  <= r_s1.packet_ready;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_read_value   = r_out.read_value;
    assign o_phase        = r_out.phase;
    assign o_packet_ready = r_out.packet_ready;

    a_ready_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_packet_ready) |-> (o_phase == lppr_pkg::PH_DONE))
        else $error("packet_ready without done phase");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_read_value != '0)) |-> (o_status == lppr_pkg::ST_OK))
        else $error("nonzero read value with error status");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lppr_pkg::PH_PAYLOAD) |-> (r_pos < r_expected))
        else $error("payload position beyond expected length");

    a_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_stall)
        else $error("request stalled with empty pipeline");

endmodule

### tb/tb_length_prefixed_packet_receiver_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for length_prefixed_packet_receiver_top.
// Runs a directed table, then random packets; checks every result against the table or predictor.
// Depends on lppr_pkg and the receiver RTL.
module tb_length_prefixed_packet_receiver_top;

    localparam int BUF_BYTES = 1024;
    localparam int HDR_BYTES = 4;
    localparam int DIR_N     = 25;
    localparam int PHASE_N   = 4;
    localparam int PHASE_ITEMS = 40;

    typedef struct packed {
        logic                            action;
        logic [lppr_pkg::RX_BYTE_W-1:0]  rx_val;
        logic [lppr_pkg::READ_IDX_W-1:0] idx;
        logic                            last;
    } t_req;

    typedef struct packed {
        t_req              req;
        logic              chk;
        lppr_pkg::t_result res;
    } t_row;

    localparam t_row DIR_TAB [0:DIR_N-1] = '{
        '{'{1'b1, 8'h00, 10'd0,    1'b1}, 1'b1,
          '{lppr_pkg::ST_NOT_DONE,  8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'hFF, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'hFF, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'hFF, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'hFF, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_TOO_LARGE, 8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h01, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h04, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_TOO_LARGE, 8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_DONE,    1'b1}},
        '{'{1'b0, 8'hA5, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_DISCARDED, 8'h00, lppr_pkg::PH_DONE,    1'b0}},
        '{'{1'b1, 8'h00, 10'd1023, 1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_DONE,    1'b0}},
        '{'{1'b1, 8'h00, 10'd0,    1'b1}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h02, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_PAYLOAD, 1'b0}},
        '{'{1'b0, 8'hFF, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_PAYLOAD, 1'b0}},
        '{'{1'b0, 8'h00, 10'd0,    1'b0}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_DONE,    1'b1}},
        '{'{1'b1, 8'h00, 10'd0,    1'b0}, 1'b0,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b1, 8'h00, 10'd1,    1'b0}, 1'b0,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}},
        '{'{1'b1, 8'h00, 10'd2,    1'b1}, 1'b1,
          '{lppr_pkg::ST_OK,        8'h00, lppr_pkg::PH_READY,   1'b0}}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic                            i_action = 1'b0;
    logic [lppr_pkg::RX_BYTE_W-1:0]  i_rx_byte = '0;
    logic [lppr_pkg::READ_IDX_W-1:0] i_read_index = '0;
    logic                            i_read_last = 1'b0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [1:0]                      o_status;
    logic [lppr_pkg::RX_BYTE_W-1:0]  o_read_value;
    logic [1:0]                      o_phase;
    logic                            o_packet_ready;

    // predictor state
    lppr_pkg::t_phase rx_ph = lppr_pkg::PH_READY;
    int          rx_pos = 0;
    logic [31:0] hdr_acc = '0;
    int          want_len = 0;
    int          got_len = 0;
    logic [7:0]  pkt_mem [0:BUF_BYTES-1];

    lppr_pkg::t_result pending_results [$];
    int      errs = 0;
    int      items_done = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_reqs = 0;
    int      hold_seen = 0;
    int      hold_left = 0;

    length_prefixed_packet_receiver_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_rx_byte      (i_rx_byte),
        .i_read_index   (i_read_index),
        .i_read_last    (i_read_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_read_value   (o_read_value),
        .o_phase        (o_phase),
        .o_packet_ready (o_packet_ready)
    );

    always #1 i_clk = ~i_clk;

    function automatic lppr_pkg::t_result next_packet_result(t_req r);
        lppr_pkg::t_result res;
        logic [31:0]       len;
        res.status       = lppr_pkg::ST_OK;
        res.read_value   = '0;
        res.packet_ready = 1'b0;
        if (!r.action) begin
            if (rx_ph == lppr_pkg::PH_READY) begin
                hdr_acc[8*rx_pos +: 8] = r.rx_val;
                rx_pos++;
                if (rx_pos >= HDR_BYTES) begin
                    len      = hdr_acc;
                    rx_pos   = 0;
                    hdr_acc  = '0;
                    want_len = 0;
                    if (len > BUF_BYTES) begin
                        res.status = lppr_pkg::ST_TOO_LARGE;
                    end else if (len == 0) begin
                        got_len          = 0;
                        rx_ph            = lppr_pkg::PH_DONE;
                        res.packet_ready = 1'b1;
                    end else begin
                        want_len = int'(len);
                        rx_ph    = lppr_pkg::PH_PAYLOAD;
                    end
                end
            end else if (rx_ph == lppr_pkg::PH_PAYLOAD) begin
                pkt_mem[10'(rx_pos)] = r.rx_val;
                rx_pos++;
                if (rx_pos >= want_len) begin
                    got_len          = want_len;
                    rx_pos           = 0;
                    hdr_acc          = '0;
                    want_len         = 0;
                    rx_ph            = lppr_pkg::PH_DONE;
                    res.packet_ready = 1'b1;
                end
            end else begin
                res.status = lppr_pkg::ST_DISCARDED;
            end
        end else if (rx_ph != lppr_pkg::PH_DONE) begin
            res.status = lppr_pkg::ST_NOT_DONE;
        end else begin
            if (int'(r.idx) < got_len) res.read_value = pkt_mem[r.idx];
            if (r.last) begin
                rx_ph    = lppr_pkg::PH_READY;
                rx_pos   = 0;
                hdr_acc  = '0;
                want_len = 0;
                got_len  = 0;
            end
        end
        res.phase = rx_ph;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errs < 100) $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        errs++;
    endtask

    task automatic send_req(t_req r, logic chk = 1'b0, lppr_pkg::t_result fixed = '0);
        lppr_pkg::t_result pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= r.action;
        i_rx_byte    <= r.rx_val;
        i_read_index <= r.idx;
        i_read_last  <= r.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = next_packet_result(r);
        pending_results.push_back(chk ? fixed : pred);
        if (pred.status != lppr_pkg::ST_DISCARDED) items_done++;
    endtask

    function automatic t_req byte_req(logic [7:0] v);
        t_req r;
        r.action = 1'b0;
        r.rx_val = v;
        r.idx    = 10'($urandom_range(0, 1023));
        r.last   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_req read_req(logic [9:0] idx, logic last);
        t_req r;
        r.action = 1'b1;
        r.rx_val = 8'($urandom_range(0, 255));
        r.idx    = idx;
        r.last   = last;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic gen_packet(logic [31:0] len, logic bounds);
        int nrd;
        for (int i = 0; i < HDR_BYTES; i++) send_req(byte_req(len[8*i +: 8]));
        if (len > BUF_BYTES) return;
        for (int i = 0; i < int'(len); i++) begin
            if ($urandom_range(0, 99) < 4)
                send_req(read_req(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))));
            send_req(byte_req(8'($urandom_range(0, 255))));
        end
        if (bounds && len != 0) begin
            send_req(read_req(10'(len - 1), 1'b0));
            send_req(read_req(10'd0, 1'b0));
        end
        nrd = $urandom_range(0, 4);
        for (int i = 0; i < nrd; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_req(byte_req(8'($urandom_range(0, 255))));
            else if (len != 0 && $urandom_range(0, 1))
                send_req(read_req(10'($urandom_range(0, len - 1)), 1'b0));
            else
                send_req(read_req(10'($urandom_range(0, 1023)), 1'b0));
        end
        send_req(read_req(10'($urandom_range(0, 1023)), 1'b1));
    endtask

    task automatic gen_sequence();
        int          pick;
        logic [31:0] len;
        t_req        r;
        if ($urandom_range(0, 99) < 10) begin
            r.action = 1'($urandom_range(0, 1));
            r.rx_val = 8'($urandom_range(0, 255));
            r.idx    = 10'($urandom_range(0, 1023));
            r.last   = 1'($urandom_range(0, 1));
            send_req(r);
            // resync to an empty header before the next packet
            while (!(rx_ph == lppr_pkg::PH_READY && rx_pos == 0)) begin
                if (rx_ph == lppr_pkg::PH_DONE)
                    send_req(read_req(10'($urandom_range(0, 1023)), 1'b1));
                else
                    send_req(byte_req(8'($urandom_range(0, 255))));
            end
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)       len = $urandom_range(32'hFFFF_FFFF, BUF_BYTES + 1);
        else if (pick < 12) len = 0;
        else if (pick < 15) len = $urandom_range(17, 128);
        else                len = $urandom_range(1, 16);
        gen_packet(len, $urandom_range(0, 3) == 0);
    endtask

    always @(posedge i_clk) begin : result_check
        lppr_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", int'(o_status), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", int'(o_read_value), int'(want.read_value));
                if (o_phase !== want.phase)
                    report_mismatch("phase", int'(o_phase), int'(want.phase));
                if (o_packet_ready !== want.packet_ready)
                    report_mismatch("packet_ready", int'(o_packet_ready),
                                    int'(want.packet_ready));
            end
        end
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 60;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++)
            send_req(DIR_TAB[i].req, DIR_TAB[i].chk, DIR_TAB[i].res);
        i_valid <= 1'b0;
        wait_drained();

        // full-size packet, then the header phase again
        gen_packet(BUF_BYTES, 1'b1);
        i_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASE_N; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default: begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            items_done = 0;
            while (items_done < PHASE_ITEMS) begin
                if (p == 0 && items_done >= 12 && hold_reqs == 0) hold_reqs <= 1;
                if (p == 1 && items_done >= 20 && items_done < 26) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
                gen_sequence();
            end
            i_valid <= 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (errs == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
